>>> sv/div128_pkg.sv
// Shared widths and the word type handed from cell to cell of the divider chain.
package div128_pkg;

   localparam int HalfWidth = 64;

   typedef logic [HalfWidth-1:0] div128_half_type;

   // rem: partial remainder; lq: unused dividend bits above, quotient bits below
   typedef struct packed {
      div128_half_type rem;
      div128_half_type lq;
      div128_half_type divisor;
      logic            err;
   } div128_word_type;

endpackage

>>> sv/div128_req_if.sv
// Request channel: dividend halves and divisor with valid/ready handshake.
interface div128_req_if
   import div128_pkg::*;
   ();
   logic            valid;
   logic            ready;
   div128_half_type dividend_high;
   div128_half_type dividend_low;
   div128_half_type divisor_value;

   modport source (output valid, output dividend_high, output dividend_low,
                   output divisor_value, input ready);
   modport sink   (input valid, input dividend_high, input dividend_low,
                   input divisor_value, output ready);
endinterface

>>> sv/div128_rsp_if.sv
// Response channel: quotient, remainder and range error with valid/ready handshake.
interface div128_rsp_if
   import div128_pkg::*;
   ();
   logic            valid;
   logic            ready;
   div128_half_type quotient_value;
   div128_half_type remainder_value;
   logic            range_error;

   modport source (output valid, output quotient_value, output remainder_value,
                   output range_error, input ready);
   modport sink   (input valid, input quotient_value, input remainder_value,
                   input range_error, output ready);
endinterface

>>> sv/divide_128_by_64.sv
// Top level of the 128-by-64 unsigned divider: range check and a chain of division cells.
// Unsigned 128-by-64 restoring divider. A request word carries the dividend as two 64-bit
// halves and the divisor; the response word carries a 64-bit quotient and remainder, or
// range_error with both zero when the high half is not below the divisor (zero divisor
// included). The divider is a chain of 64 identical cells, one per quotient bit, each doing
// one 64-bit subtract and compare and registering its word. A new request is taken in every
// cycle while the first cell is ready; results come out in the order their requests went in.
// Each cell stalls on its own, so empty cells accept while the response waits to be taken.
module divide_128_by_64
   import div128_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   div128_req_if.sink   req_port,
   div128_rsp_if.source rsp_port
);

   logic            chain_valid [0:HalfWidth];
   logic            chain_ready [0:HalfWidth];
   div128_word_type chain_word  [0:HalfWidth];

   assign chain_valid[0]      = req_port.valid;
   assign req_port.ready      = chain_ready[0];
   assign chain_word[0].rem     = req_port.dividend_high;
   assign chain_word[0].lq      = req_port.dividend_low;
   assign chain_word[0].divisor = req_port.divisor_value;
   assign chain_word[0].err     = req_port.dividend_high >= req_port.divisor_value;

   for (genvar i = 0; i < HalfWidth; i++) begin : g_cell
      div128_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   assign rsp_port.valid           = chain_valid[HalfWidth];
   assign chain_ready[HalfWidth]   = rsp_port.ready;
   assign rsp_port.quotient_value  = chain_word[HalfWidth].err ? '0 : chain_word[HalfWidth].lq;
   assign rsp_port.remainder_value = chain_word[HalfWidth].err ? '0 : chain_word[HalfWidth].rem;
   assign rsp_port.range_error     = chain_word[HalfWidth].err;

   a_zero_div_err: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.divisor_value == '0 |-> chain_word[0].err)
      else $error("zero divisor not flagged");

   a_err_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.range_error
         |-> rsp_port.quotient_value == '0 && rsp_port.remainder_value == '0)
      else $error("error word with non-zero fields");

   a_rem_out: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.range_error
         |-> rsp_port.remainder_value < chain_word[HalfWidth].divisor)
      else $error("remainder not below divisor");

endmodule

>>> sv/div128_cell.sv
// One restoring shift-and-subtract step with its own word register and handshake.
module div128_cell
   import div128_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  div128_word_type in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output div128_word_type out_word
);

   logic            valid_ff;
   logic            valid_in;
   div128_word_type word_ff;
   div128_word_type word_in;
   div128_half_type shifted;
   logic [HalfWidth:0] diff;
   logic            take;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      shifted = {in_word.rem[HalfWidth-2:0], in_word.lq[HalfWidth-1]};
      diff    = {1'b0, shifted} - {1'b0, in_word.divisor};
      // a bit carried out of the top always exceeds the divisor
      take    = in_word.rem[HalfWidth-1] || !diff[HalfWidth];
      word_in         = in_word;
      word_in.rem     = take ? diff[HalfWidth-1:0] : shifted;
      word_in.lq      = {in_word.lq[HalfWidth-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // a word that passed the range check keeps its remainder below the divisor
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !word_ff.err |-> word_ff.rem < word_ff.divisor)
      else $error("partial remainder not below divisor");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(word_ff))
      else $error("stalled word lost or changed");

   a_carry_flags: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> word_ff.err == $past(in_word.err)
                               && word_ff.divisor == $past(in_word.divisor))
      else $error("error flag or divisor not carried");

endmodule

>>> bench/divide_128_by_64_tb.sv
// Self-checking bench for the 128-by-64 restoring divider: directed corners, random words, stalls.
module divide_128_by_64_tb;
   import div128_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned RandomCount = 2000;
   localparam int unsigned HoldOffCycles = 300;
   localparam int unsigned DrainCycles = 80;
   localparam div128_half_type AllOnes = '1;
   localparam div128_half_type TopBit = {1'b1, {(HalfWidth-1){1'b0}}};

   // Predicts each quotient and remainder and holds them until the response word arrives.
   class division_ledger;
      typedef struct {
         div128_half_type quotient_value;
         div128_half_type remainder_value;
         logic            range_error;
      } quotient_rec_type;

      quotient_rec_type awaited[$];
      int unsigned      failures;
      int unsigned      reported;
      int unsigned      results_seen;
      int unsigned      overflows_sent;

      function quotient_rec_type restoring_divide(div128_half_type hi, div128_half_type lo,
                                                  div128_half_type d);
         quotient_rec_type rec;
         div128_half_type  part;
         logic             carry;
         rec.quotient_value  = '0;
         rec.remainder_value = '0;
         rec.range_error     = 1'b0;
         if (hi >= d) begin
            rec.range_error = 1'b1;
            return rec;
         end
         part = hi;
         for (int pos = HalfWidth - 1; pos >= 0; pos--) begin
            // a bit shifted out of the top always means the divisor fits
            carry = part[HalfWidth-1];
            part  = {part[HalfWidth-2:0], lo[pos]};
            if (carry || part >= d) begin
               part = part - d;
               rec.quotient_value[pos] = 1'b1;
            end
         end
         rec.remainder_value = part;
         return rec;
      endfunction

      function void note_request(div128_half_type hi, div128_half_type lo,
                                 div128_half_type d);
         if (hi >= d)
            overflows_sent++;
         awaited.push_back(restoring_divide(hi, lo, d));
      endfunction

      function void report(string msg);
         failures++;
         if (reported < 10) begin
            reported++;
            $display("ERROR: %s", msg);
         end
      endfunction

      function void check_response(div128_half_type q, div128_half_type r, logic e);
         quotient_rec_type want;
         results_seen++;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected word q=%h r=%h err=%b", q, r, e));
            return;
         end
         want = awaited.pop_front();
         if (q !== want.quotient_value || r !== want.remainder_value
             || e !== want.range_error)
            report($sformatf("word %0d: expected q=%h r=%h err=%b, got q=%h r=%h err=%b",
                             results_seen, want.quotient_value, want.remainder_value,
                             want.range_error, q, r, e));
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic           clock;
   logic           reset;
   int unsigned    cycle_count;
   int unsigned    stall_left;
   bit             calm;
   int unsigned    words_sent;
   division_ledger ledger;

   div128_req_if req_bus();
   div128_rsp_if rsp_bus();

   divide_128_by_64 u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.dividend_high = '0;
      req_bus.dividend_low  = '0;
      req_bus.divisor_value = '0;
      rsp_bus.ready         = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("divide_128_by_64 regression: fail");
      $finish;
   end

   // Receiver: random back-pressure, or a counted hold-off when one is requested.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = calm || ($urandom_range(99) >= 14);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            ledger.check_response(rsp_bus.quotient_value, rsp_bus.remainder_value,
                                  rsp_bus.range_error);
      end
   end

   function automatic div128_half_type rand_half();
      return {$urandom, $urandom};
   endfunction

   task automatic offer_division(input div128_half_type hi, input div128_half_type lo,
                                 input div128_half_type d);
      while (!calm && $urandom_range(99) < 14) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.dividend_high = hi;
      req_bus.dividend_low  = lo;
      req_bus.divisor_value = d;
      req_bus.valid         = 1'b1;
      do
         @(posedge clock);
      while (!req_bus.ready);
      ledger.note_request(hi, lo, d);
      words_sent++;
   endtask

   task automatic offer_random_division();
      div128_half_type hi;
      div128_half_type lo;
      div128_half_type d;
      int unsigned     pick;
      pick = $urandom_range(99);
      // favour full-width divisors now and then so the shift carry gets exercised
      d    = rand_half() >> (($urandom_range(3) == 0) ? 0 : $urandom_range(HalfWidth - 1));
      lo   = rand_half();
      if (pick < 80) begin
         if (d == 0)
            d = 1;
         case ($urandom_range(9))
            0: hi = '0;
            1: hi = d - 1;
            default: hi = rand_half() % d;
         endcase
      end else if (pick < 90) begin
         hi = d + (rand_half() >> $urandom_range(HalfWidth - 1));
         if (hi < d)
            hi = AllOnes;
      end else if (pick < 95) begin
         hi = d;
      end else begin
         d  = '0;
         hi = rand_half() >> $urandom_range(HalfWidth - 1);
      end
      offer_division(hi, lo, d);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      ledger = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners: zero and full-scale fields, equal and greater high half, zero divisor
      offer_division('0, '0, 64'd1);
      offer_division('0, AllOnes, 64'd1);
      offer_division('0, '0, '0);
      offer_division(AllOnes, AllOnes, '0);
      offer_division(AllOnes, AllOnes, AllOnes);
      offer_division(AllOnes - 1, AllOnes, AllOnes);
      offer_division(AllOnes - 1, '0, AllOnes);
      offer_division(64'd5, 64'd0, 64'd5);
      offer_division(64'd6, 64'd7, 64'd5);
      offer_division('0, 64'd12345, AllOnes);
      offer_division('0, TopBit, TopBit);
      offer_division(64'd1, '0, 64'd2);
      offer_division(TopBit, AllOnes, TopBit + 1);
      offer_division(TopBit - 1, '0, TopBit);
      offer_division(AllOnes - 1, 64'h5555_5555_5555_5555, AllOnes);
      offer_division(64'h2AAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      offer_division(64'd3, 64'hFEDC_BA98_7654_3210, 64'd7);
      offer_division(AllOnes, '0, 64'd1);
      drain_results();

      for (int i = 0; i < RandomCount / 4; i++)
         offer_random_division();

      // back-to-back words; hold the receiver off long enough for the chain to fill
      calm = 1'b1;
      for (int i = 0; i < RandomCount / 4; i++) begin
         if (i == 40)
            stall_left = HoldOffCycles;
         offer_random_division();
      end
      calm = 1'b0;
      drain_results();

      for (int i = 0; i < RandomCount / 2; i++) begin
         if (i == RandomCount / 4)
            stall_left = HoldOffCycles;
         offer_random_division();
      end
      drain_results();
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d divisions (%0d out of range or by zero), checked %0d results",
               words_sent, ledger.overflows_sent, ledger.results_seen);
      $display("%0d failures in %0d cycles", ledger.failures, cycle_count);
      if (ledger.failures == 0 && ledger.pending() == 0)
         $display("divide_128_by_64 regression: pass");
      else
         $display("divide_128_by_64 regression: fail");
      $finish;
   end

endmodule
